>>> src/knr_pkg.sv
package knr_pkg;

    localparam int COL_W  = 12;
    localparam int DIST_W = 31;
    localparam int RAW_W  = 32;
    localparam int RANK_W = 6;
    localparam int CFG_W  = 6;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [DIST_W-1:0] distance;
    } entry_t;

    // what one cell shows its neighbors
    typedef struct packed {
        logic   ge;      // held and key ranks at or after this entry
        logic   valid;
        entry_t e;
    } link_t;

    // broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   drain;
        logic   clear;
        entry_t key;
    } cell_ctrl_t;

endpackage

>>> src/knr_cell.sv
module knr_cell #(
    parameter int IDX    = 0,
    parameter int KEEP_W = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  knr_pkg::cell_ctrl_t ctrl,
    input  logic [KEEP_W-1:0]   keep,
    input  knr_pkg::link_t      prev_link,
    input  knr_pkg::link_t      next_link,
    output knr_pkg::link_t      link
);

    logic            valid_reg;
    logic            valid_next;
    knr_pkg::entry_t entry_reg;
    knr_pkg::entry_t entry_next;
    logic            key_less;
    logic            ge;
    logic            in_range;

    assign key_less = (ctrl.key.distance < entry_reg.distance)
                   || ((ctrl.key.distance == entry_reg.distance)
                       && (ctrl.key.col < entry_reg.col));
    assign ge       = valid_reg && !key_less;
    assign in_range = KEEP_W'(IDX) < keep;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.drain)
        begin
            valid_next = next_link.valid;
            entry_next = next_link.e;
        end
        else if (ctrl.ins)
        begin
            if (!in_range)
            begin
                valid_next = 1'b0;
            end
            else if (prev_link.ge && !ge)
            begin
                valid_next = 1'b1;
                entry_next = ctrl.key;
            end
            else if (!prev_link.ge)
            begin
                valid_next = prev_link.valid;
                entry_next = prev_link.e;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign link.ge    = ge;
    assign link.valid = valid_reg;
    assign link.e     = entry_reg;

endmodule

>>> src/k_nearest_from_distance_row_top.sv
// Nearest-entry selection over one distance-matrix row. Row items arrive one
// beat per cycle while s_axis_tready is high and go through a one-beat input
// stage, then into a chain of MAX_WANTED+1 compare cells that keeps the
// smallest |distance| entries sorted by (distance, column); each insert
// updates every cell at once. After the tlast beat, ST_FINISH does the final
// insert and ST_DROP drops the closest entry (the row's own stop); then the
// chain shifts toward the output one result per cycle unless the output
// stalls, up to count_wanted (clamped to 1..MAX_WANTED) beats with rank 1..n
// and tlast on the last one. The input is held off from the tlast beat until
// the final result is loaded; the next row may start the cycle after that.
// Columns not below MAX_COLUMNS are dropped but their tlast still ends the row.
module k_nearest_from_distance_row_top #(
    parameter int MAX_WANTED  = 32,
    parameter int MAX_COLUMNS = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // column_index[11:0], raw_distance[43:12], zero
    input  logic        s_axis_tlast,  // row_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // near_column[11:0], near_distance[42:12],
                                       // near_rank[48:43], zero
    output logic        m_axis_tlast,  // final_result
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data       // count_wanted
);

    localparam int DEPTH  = MAX_WANTED + 1;
    localparam int KEEP_W = $clog2(MAX_WANTED + 2);
    localparam int RW     = $clog2(MAX_WANTED + 1);

    typedef enum logic [3:0] {
        ST_ACCEPT = 4'b0001,
        ST_FINISH = 4'b0010,
        ST_DROP   = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [knr_pkg::CFG_W-1:0] wanted_reg;
    logic [RW-1:0]             eff_wanted;
    logic [KEEP_W-1:0]         keep;

    logic                      stage_valid_reg;
    logic                      stage_en_reg;
    knr_pkg::entry_t           stage_key_reg;

    logic [knr_pkg::COL_W-1:0]  in_col;
    logic [knr_pkg::RAW_W-1:0]  in_raw;
    logic [knr_pkg::RAW_W-1:0]  neg_raw;
    logic [knr_pkg::DIST_W-1:0] in_mag;
    logic                       in_accept;

    knr_pkg::cell_ctrl_t ctrl;
    knr_pkg::link_t      cell_link [DEPTH];
    knr_pkg::link_t      prev_link [DEPTH];
    knr_pkg::link_t      next_link [DEPTH];
    logic [DEPTH-1:0]    cell_valid;

    logic [RW-1:0]       rank_reg, rank_next;
    logic [RW-1:0]       rank_inc;
    logic                can_load;
    logic                load;
    logic                final_beat;

    logic                out_valid_reg;
    logic                out_last_reg;
    knr_pkg::entry_t     out_entry_reg;
    logic [RW-1:0]       out_rank_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_reg <= knr_pkg::CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            wanted_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (wanted_reg == '0)
        begin
            eff_wanted = RW'(1);
        end
        else if (wanted_reg > knr_pkg::CFG_W'(MAX_WANTED))
        begin
            eff_wanted = RW'(MAX_WANTED);
        end
        else
        begin
            eff_wanted = RW'(wanted_reg);
        end
    end

    assign keep = KEEP_W'(eff_wanted) + KEEP_W'(1);

    // input stage: absolute value with saturation of the most negative code
    assign in_col    = s_axis_tdata[11:0];
    assign in_raw    = s_axis_tdata[43:12];
    assign neg_raw   = ~in_raw + knr_pkg::RAW_W'(1);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (!in_raw[knr_pkg::RAW_W-1])
        begin
            in_mag = in_raw[knr_pkg::DIST_W-1:0];
        end
        else if (neg_raw[knr_pkg::RAW_W-1])
        begin
            in_mag = '1;
        end
        else
        begin
            in_mag = neg_raw[knr_pkg::DIST_W-1:0];
        end
    end

    assign s_axis_tready = (state_reg == ST_ACCEPT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_en_reg           <= 32'(in_col) < 32'(MAX_COLUMNS);
            stage_key_reg.col      <= in_col;
            stage_key_reg.distance <= in_mag;
        end
    end

    // cell chain
    assign can_load   = !out_valid_reg || m_axis_tready;
    assign rank_inc   = rank_reg + RW'(1);
    assign final_beat = !cell_link[1].valid || (rank_inc == eff_wanted);
    assign load       = (state_reg == ST_EMIT) && cell_link[0].valid && can_load;

    always_comb
    begin
        ctrl.key   = stage_key_reg;
        ctrl.ins   = stage_valid_reg && stage_en_reg;
        ctrl.drain = (state_reg == ST_DROP) || (load && !final_beat);
        ctrl.clear = ((state_reg == ST_EMIT) && !cell_link[0].valid) || (load && final_beat);
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign prev_link[g] = '{ge: 1'b1, valid: 1'b1, e: '0};
            end
            else
            begin : g_body
                assign prev_link[g] = cell_link[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_tail
                assign next_link[g] = '0;
            end
            else
            begin : g_mid
                assign next_link[g] = cell_link[g+1];
            end

            knr_cell #(
                .IDX    (g),
                .KEEP_W (KEEP_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .keep      (keep),
                .prev_link (prev_link[g]),
                .next_link (next_link[g]),
                .link      (cell_link[g])
            );

            assign cell_valid[g] = cell_link[g].valid;
        end
    endgenerate

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        rank_next  = rank_reg;
        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (in_accept && s_axis_tlast)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_DROP;
            end
            ST_DROP:
            begin
                state_next = ST_EMIT;
                rank_next  = '0;
            end
            ST_EMIT:
            begin
                if (!cell_link[0].valid)
                begin
                    state_next = ST_ACCEPT;
                end
                else if (can_load)
                begin
                    rank_next = rank_inc;
                    if (final_beat)
                    begin
                        state_next = ST_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rank_reg  <= rank_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_entry_reg <= cell_link[0].e;
            out_rank_reg  <= rank_inc;
            out_last_reg  <= final_beat;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {7'd0, knr_pkg::RANK_W'(out_rank_reg),
                            out_entry_reg.distance, out_entry_reg.col};

`ifndef ASSERT_OFF
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("cell chain valid bits not a prefix");

    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_rank_reg != '0) && (out_rank_reg <= eff_wanted))
        else $error("result rank out of range");

    a_last_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (state_reg == ST_FINISH))
        else $error("row end did not start finishing");

    a_final_back: assert property (@(posedge clk) disable iff (!rst_n)
        (load && final_beat) |=> (state_reg == ST_ACCEPT) && (cell_valid == '0))
        else $error("chain not cleared after final result");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int MAX_WANTED  = 32;
    localparam int MAX_COLUMNS = 4096;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 40;

    typedef struct packed {
        logic [knr_pkg::COL_W-1:0]  col;
        logic [knr_pkg::DIST_W-1:0] distance;
        logic [knr_pkg::RANK_W-1:0] rank;
        logic                       last;
    } near_beat_t;

    typedef struct packed {
        logic [knr_pkg::COL_W-1:0]  col;
        logic [knr_pkg::RAW_W-1:0]  raw;
        logic                       last;
        logic                       typed;
        logic [knr_pkg::COL_W-1:0]  t_col;
        logic [knr_pkg::DIST_W-1:0] t_dist;
    } row_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;

    k_nearest_from_distance_row_top #(
        .MAX_WANTED  (MAX_WANTED),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // sorted nearest list, mirrors the compare chain
    logic [knr_pkg::DIST_W-1:0] kept_dist [MAX_WANTED+1];
    logic [knr_pkg::COL_W-1:0]  kept_col  [MAX_WANTED+1];
    int                         kept_count;
    logic [knr_pkg::CFG_W-1:0]  count_reg;

    near_beat_t expected_near [$];
    near_beat_t row_results [$];

    int mismatch_count;
    int quiet_cycles;
    bit idle_on;
    bit hold_req;

    // at reset count_wanted = 1, so each row end yields at most one beat
    row_item_t directed_rows [18] = '{
        '{12'd0,    32'h0000_0000, 1'b1, 1'b0, 12'd0,    31'd0},
        '{12'd10,   32'h0000_0000, 1'b0, 1'b0, 12'd0,    31'd0},
        '{12'd4095, 32'h7FFF_FFFF, 1'b1, 1'b1, 12'd4095, 31'h7FFF_FFFF},
        '{12'd1,    32'h0000_0000, 1'b0, 1'b0, 12'd0,    31'd0},
        '{12'd2,    32'h8000_0000, 1'b1, 1'b1, 12'd2,    31'h7FFF_FFFF},
        '{12'd5,    32'h0000_0000, 1'b0, 1'b0, 12'd0,    31'd0},
        '{12'd3,    32'd100,       1'b0, 1'b0, 12'd0,    31'd0},
        '{12'd7,    32'hFFFF_FF9C, 1'b1, 1'b1, 12'd3,    31'd100},
        '{12'd9,    32'h0000_0000, 1'b0, 1'b0, 12'd0,    31'd0},
        '{12'd8,    32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0,    31'd0},
        '{12'd8,    32'hFFFF_FFFF, 1'b0, 1'b0, 12'd0,    31'd0},
        '{12'd8,    32'd1,         1'b1, 1'b1, 12'd8,    31'd1},
        '{12'd0,    32'h0000_0000, 1'b0, 1'b0, 12'd0,    31'd0},
        '{12'd0,    32'h0000_0000, 1'b1, 1'b1, 12'd0,    31'd0},
        '{12'd1,    32'd500,       1'b0, 1'b0, 12'd0,    31'd0},
        '{12'd2,    32'd300,       1'b0, 1'b0, 12'd0,    31'd0},
        '{12'd3,    32'd0,         1'b0, 1'b0, 12'd0,    31'd0},
        '{12'd4,    32'd400,       1'b1, 1'b1, 12'd2,    31'd300}
    };

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int wanted_now();
        if (count_reg < 1)
            return 1;
        if (count_reg > MAX_WANTED)
            return MAX_WANTED;
        return int'(count_reg);
    endfunction

    function automatic void rank_row_item(input logic [knr_pkg::COL_W-1:0] col,
                                          input logic [knr_pkg::RAW_W-1:0] raw,
                                          input logic last);
        logic [knr_pkg::RAW_W-1:0]  neg;
        logic [knr_pkg::DIST_W-1:0] mag;
        int                         wanted;
        int                         keep;
        int                         n;
        int                         pos;
        near_beat_t                 b;
        row_results.delete();
        wanted = wanted_now();
        keep   = wanted + 1;
        neg    = -raw;
        if (raw[knr_pkg::RAW_W-1])
            mag = (neg > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : neg[knr_pkg::DIST_W-1:0];
        else
            mag = raw[knr_pkg::DIST_W-1:0];
        if (col < MAX_COLUMNS)
        begin
            n = (kept_count > keep) ? keep : kept_count;
            pos = 0;
            while (pos < n && !(mag < kept_dist[pos] ||
                   (mag == kept_dist[pos] && col < kept_col[pos])))
                pos++;
            if (pos >= keep)
                kept_count = n;
            else
            begin
                if (n < keep)
                    n++;
                for (int i = n - 1; i > pos; i--)
                begin
                    kept_dist[i] = kept_dist[i-1];
                    kept_col[i]  = kept_col[i-1];
                end
                kept_dist[pos] = mag;
                kept_col[pos]  = col;
                kept_count     = n;
            end
        end
        if (last)
        begin
            // entry 0 is the stop itself and is dropped
            n = (kept_count > 0) ? kept_count - 1 : 0;
            if (n > wanted)
                n = wanted;
            for (int k = 0; k < n; k++)
            begin
                b.col      = kept_col[k+1];
                b.distance = kept_dist[k+1];
                b.rank     = knr_pkg::RANK_W'(k + 1);
                b.last     = (k + 1 == n);
                row_results.push_back(b);
            end
            kept_count = 0;
        end
    endfunction

    task automatic send_beat(input logic [knr_pkg::COL_W-1:0] col,
                             input logic [knr_pkg::RAW_W-1:0] raw,
                             input logic last, input bit keep_predicted);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0, raw, col};
        s_axis_tlast  = last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        rank_row_item(col, raw, last);
        if (keep_predicted)
            foreach (row_results[i])
                expected_near.push_back(row_results[i]);
        @(negedge clk);
    endtask

    task automatic send_random_row(input int len);
        int                        self_at;
        bit                        formed;
        logic [knr_pkg::COL_W-1:0] col;
        logic [knr_pkg::RAW_W-1:0] raw;
        formed  = ($urandom_range(0, 4) != 0);
        self_at = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 1))
                col = knr_pkg::COL_W'($urandom_range(0, 4095));
            else
                col = knr_pkg::COL_W'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
                0:
                begin
                    raw = knr_pkg::RAW_W'($urandom_range(0, 30));
                    if ($urandom_range(0, 1))
                        raw = -raw;
                end
                1: raw = $urandom();
                2:
                begin
                    case ($urandom_range(0, 5))
                        0: raw = 32'h0000_0000;
                        1: raw = 32'h0000_0001;
                        2: raw = 32'hFFFF_FFFF;
                        3: raw = 32'h7FFF_FFFF;
                        4: raw = 32'h8000_0000;
                        default: raw = 32'h8000_0001;
                    endcase
                end
                default: raw = knr_pkg::RAW_W'($urandom_range(0, 200000) - 100000);
            endcase
            if (formed && i == self_at)
                raw = '0;
            send_beat(col, raw, i == len - 1, 1'b1);
        end
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (expected_near.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_count(input logic [knr_pkg::CFG_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        count_reg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // result sink: random stalls, one long hold on request
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req      = 1'b0;
                m_axis_tready = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready = 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        near_beat_t exp_beat;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_near.size() == 0)
            begin
                $error("unexpected result beat: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end
            else
            begin
                exp_beat = expected_near.pop_front();
                if (m_axis_tdata[11:0] !== exp_beat.col)
                begin
                    $error("near_column expected %0d actual %0d",
                           exp_beat.col, m_axis_tdata[11:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[42:12] !== exp_beat.distance)
                begin
                    $error("near_distance expected %0d actual %0d",
                           exp_beat.distance, m_axis_tdata[42:12]);
                    mismatch_count++;
                end
                if (m_axis_tdata[48:43] !== exp_beat.rank)
                begin
                    $error("near_rank expected %0d actual %0d",
                           exp_beat.rank, m_axis_tdata[48:43]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== exp_beat.last)
                begin
                    $error("final_result expected %0d actual %0d",
                           exp_beat.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int         plan [7];
        int         sent;
        int         len;
        int         wanted;
        bit         first_row;
        bit         phase_idle;
        near_beat_t typed_beat;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        kept_count     = 0;
        count_reg      = 6'd1;
        plan = '{0, 32, 3, 63, 2, 0, 1};
        plan[5] = $urandom_range(4, 31);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        foreach (directed_rows[r])
        begin
            send_beat(directed_rows[r].col, directed_rows[r].raw,
                      directed_rows[r].last, !directed_rows[r].typed);
            if (directed_rows[r].typed)
            begin
                typed_beat.col      = directed_rows[r].t_col;
                typed_beat.distance = directed_rows[r].t_dist;
                typed_beat.rank     = 6'd1;
                typed_beat.last     = 1'b1;
                expected_near.push_back(typed_beat);
            end
        end

        for (int p = 0; p < 7; p++)
        begin
            drain_and_settle();
            write_count(knr_pkg::CFG_W'(plan[p]));
            if (p == 1)
                hold_req = 1'b1;
            phase_idle = (p != 6);
            sent       = 0;
            first_row  = 1'b1;
            while (sent < 14)
            begin
                wanted  = wanted_now();
                idle_on = phase_idle && ($urandom_range(0, 3) != 0);
                if (first_row && wanted == MAX_WANTED)
                    len = wanted + 2;
                else
                    len = $urandom_range(1, wanted + 3);
                send_random_row(len);
                sent += len;
                first_row = 1'b0;
            end
        end

        drain_and_settle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
